>>> rtl/wftc_pkg.sv
`timescale 1ns / 1ps
package wftc_pkg;

  // Mode codes as they appear on the result word
  localparam logic [1:0] MODE_COAST = 2'd0;
  localparam logic [1:0] MODE_CURVE = 2'd1;
  localparam logic [1:0] MODE_WALL  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_SPEED_LIMIT   = 3'd0;
  localparam logic [2:0] REG_CURVE_GAIN    = 3'd1;
  localparam logic [2:0] REG_WALL_GAIN     = 3'd2;
  localparam logic [2:0] REG_WALL_SETPOINT = 3'd3;
  localparam logic [2:0] REG_OPEN_THRESH   = 3'd4;
  localparam logic [2:0] REG_STOP_DIST     = 3'd5;
  localparam logic [2:0] REG_ALIGNED_TOL   = 3'd6;
  localparam logic [2:0] REG_RUN_TICKS     = 3'd7;

  // Binary angles (65536 = 2 pi)
  localparam logic [15:0] ANGLE_LEFT  = 16'd16384;
  localparam logic [15:0] ANGLE_FRONT = 16'd0;
  localparam logic [15:0] ANGLE_RIGHT = 16'd49152;
  localparam logic [15:0] ANGLE_BACK  = 16'd32768;

  localparam logic [11:0] SEED_THRESHOLD = 12'd160;

  // Gyro scale: round(2^24 * 0.128 / pi); the tick of 64 ms folds into the shift
  localparam logic [19:0] GYRO_Q24   = 20'd683565;
  localparam int          GYRO_SHIFT = 24 - 6;
  // Reciprocal of five, exact for dividends below 2^17
  localparam logic [19:0] RECIP_FIVE = 20'd52429;
  localparam int          RECIP_SHIFT = 18;

  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 20;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic load;    // word accepted: latch inputs, seed on the first tick
    logic mul1;    // gyro step or base speed product
    logic upd;     // integrate heading or take base speed
    logic mul2;    // gain product
    logic commit;  // update state, load the result register
  } wftc_cmd_t;

  typedef struct packed {
    logic out_free;  // result register empty or being taken this cycle
  } wftc_status_t;

  function automatic logic [15:0] pick_side(input logic [11:0] l, input logic [11:0] f,
                                            input logic [11:0] r, input logic [11:0] thr);
    if (l >= thr) return ANGLE_LEFT;
    else if (f >= thr) return ANGLE_FRONT;
    else if (r >= thr) return ANGLE_RIGHT;
    else return ANGLE_BACK;
  endfunction

endpackage

>>> rtl/wftc_ctrl.sv
`timescale 1ns / 1ps
module wftc_ctrl
  import wftc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  wftc_status_t status,
  output wftc_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold until the result register can take the word
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/wftc_dp.sv
`timescale 1ns / 1ps
module wftc_dp
  import wftc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  wftc_cmd_t    cmd,
  output wftc_status_t status,
  input  logic [55:0]  in_tdata,
  input  logic         cfg_valid,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [55:0]  out_tdata
);

  // Configuration
  logic [14:0] speed_lim_r;
  logic [15:0] curve_gain_r, wall_gain_r;
  logic [11:0] wall_setpoint_r, open_thresh_r, stop_dist_r;
  logic [14:0] aligned_tol_r;
  logic [7:0]  run_ticks_r;

  // Controller state
  logic        first_tick_r, first_tick_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [1:0]  mac_r, mac_nxt;
  logic [15:0] target_r, target_nxt;
  logic [15:0] heading_r, heading_nxt;
  logic [7:0]  cc_r, cc_nxt;

  // Working registers
  logic [11:0]        left_r, front_r, right_r;
  logic [15:0]        yaw_r;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [14:0]        base_r, base_nxt;
  logic               neg_r, neg_nxt;
  logic [15:0]        aerr_r, aerr_nxt;
  logic               out_valid_r;
  logic [55:0]        out_data_r, out_data_nxt;

  logic [11:0] in_left, in_front, in_right;
  logic [15:0] yaw_mag, err, du, ls, rs;
  logic [35:0] gsum;
  logic [12:0] e;
  logic [11:0] emag;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [32:0] rsum;
  logic [23:0] rnd;
  logic [14:0] pm;
  logic signed [25:0] p26, base26;
  logic [15:0] dir;

  function automatic logic [15:0] clamp_spd(input logic signed [25:0] v,
                                            input logic [14:0] m);
    logic signed [25:0] ms;
    ms = $signed({11'b0, m});
    if (v > ms) return {1'b0, m};
    else if (v < -ms) return 16'(-ms);
    else return v[15:0];
  endfunction

  assign in_left  = in_tdata[11:0];
  assign in_front = in_tdata[23:12];
  assign in_right = in_tdata[35:24];

  assign status.out_free = !out_valid_r || out_tready;
  assign out_tvalid      = out_valid_r;
  assign out_tdata       = out_data_r;

  // Shared unsigned multiplier
  assign yaw_mag = yaw_r[15] ? 16'(-yaw_r) : yaw_r;
  assign err     = target_r - heading_r;
  assign e       = {1'b0, left_r} - {1'b0, wall_setpoint_r};
  assign emag    = e[12] ? 12'(-e) : e[11:0];

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    neg_nxt  = neg_r;
    aerr_nxt = aerr_r;
    if (cmd.mul1) begin
      if (mode_r == MODE_CURVE) begin
        mul_a = {1'b0, yaw_mag};
        mul_b = GYRO_Q24;
      end else begin
        mul_a = {speed_lim_r, 2'b10};  // 4 * limit + 2
        mul_b = RECIP_FIVE;
      end
    end else if (cmd.mul2) begin
      if (mode_r == MODE_CURVE) begin
        neg_nxt  = err[15];
        aerr_nxt = err[15] ? 16'(-err) : err;
        mul_a    = {1'b0, aerr_nxt};
        mul_b    = {4'b0, curve_gain_r};
      end else begin
        neg_nxt = e[12];
        mul_a   = {5'b0, emag};
        mul_b   = {4'b0, wall_gain_r};
      end
    end
    prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Gyro step, rounded; magnitude then sign
  assign gsum = prod_r[35:0] + (36'd1 << (GYRO_SHIFT - 1));
  assign du   = gsum[GYRO_SHIFT +: 16];

  // Gain product divided by 256, rounded half away from zero
  assign rsum = {1'b0, prod_r[31:0]} + 33'd128;
  assign rnd  = rsum[31:8];
  assign pm   = (rnd > {9'b0, speed_lim_r}) ? speed_lim_r : rnd[14:0];
  assign p26  = neg_r ? -$signed({2'b0, rnd}) : $signed({2'b0, rnd});
  assign base26 = $signed({11'b0, base_r});
  assign dir  = pick_side(left_r, front_r, right_r, open_thresh_r);

  always_comb begin
    first_tick_nxt = first_tick_r;
    mode_nxt       = mode_r;
    mac_nxt        = mac_r;
    target_nxt     = target_r;
    heading_nxt    = heading_r;
    cc_nxt         = cc_r;
    base_nxt       = base_r;
    ls             = '0;
    rs             = '0;
    out_data_nxt   = out_data_r;

    if (cmd.load && first_tick_r) begin
      first_tick_nxt = 1'b0;
      mode_nxt       = MODE_WALL;
      target_nxt     = target_r + pick_side(in_left, in_front, in_right, SEED_THRESHOLD);
    end

    if (cmd.upd) begin
      if (mode_r == MODE_CURVE) begin
        heading_nxt = yaw_r[15] ? heading_r - du : heading_r + du;
      end else begin
        base_nxt = prod_r[RECIP_SHIFT +: 15];
      end
    end

    if (cmd.commit) begin
      unique case (mode_r)
        MODE_COAST: begin
          if (cc_r > run_ticks_r) mode_nxt = mac_r;
          rs = (front_r <= stop_dist_r) ? 16'd0 : {1'b0, speed_lim_r};
          ls = rs;
        end
        MODE_CURVE: begin
          rs = neg_r ? 16'(-{1'b0, pm}) : {1'b0, pm};
          ls = 16'(-rs);
          if (aerr_r < {1'b0, aligned_tol_r}) begin
            mode_nxt    = MODE_COAST;
            mac_nxt     = MODE_WALL;
            cc_nxt      = '0;
            heading_nxt = '0;
            target_nxt  = '0;
          end
        end
        default: begin
          rs = clamp_spd(base26 + p26, speed_lim_r);
          ls = clamp_spd(base26 - p26, speed_lim_r);
          if (dir != target_r) begin
            cc_nxt     = '0;
            mode_nxt   = MODE_COAST;
            target_nxt = dir;
            mac_nxt    = MODE_CURVE;
            rs         = {1'b0, base_r};
            ls         = {1'b0, base_r};
          end
        end
      endcase
      // saturating tick count, advanced at the end of every tick
      if (cc_nxt != 8'hFF) cc_nxt = cc_nxt + 8'd1;
      out_data_nxt = {6'b0, target_nxt, mode_nxt, rs, ls};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_lim_r     <= 15'd2145;
      curve_gain_r    <= 16'd314;
      wall_gain_r     <= 16'd4915;
      wall_setpoint_r <= 12'd112;
      open_thresh_r   <= 12'd240;
      stop_dist_r     <= 12'd64;
      aligned_tol_r   <= 15'd104;
      run_ticks_r     <= 8'd13;
      first_tick_r    <= 1'b1;
      mode_r          <= MODE_CURVE;
      mac_r           <= MODE_CURVE;
      target_r        <= '0;
      heading_r       <= '0;
      cc_r            <= 8'hFF;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SPEED_LIMIT:   speed_lim_r     <= cfg_data[14:0];
          REG_CURVE_GAIN:    curve_gain_r    <= cfg_data;
          REG_WALL_GAIN:     wall_gain_r     <= cfg_data;
          REG_WALL_SETPOINT: wall_setpoint_r <= cfg_data[11:0];
          REG_OPEN_THRESH:   open_thresh_r   <= cfg_data[11:0];
          REG_STOP_DIST:     stop_dist_r     <= cfg_data[11:0];
          REG_ALIGNED_TOL:   aligned_tol_r   <= cfg_data[14:0];
          REG_RUN_TICKS:     run_ticks_r     <= cfg_data[7:0];
          default: ;
        endcase
      end
      first_tick_r <= first_tick_nxt;
      mode_r       <= mode_nxt;
      mac_r        <= mac_nxt;
      target_r     <= target_nxt;
      heading_r    <= heading_nxt;
      cc_r         <= cc_nxt;
      if (cmd.commit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left_r  <= in_left;
      front_r <= in_front;
      right_r <= in_right;
      yaw_r   <= in_tdata[51:36];
    end
    if (cmd.mul1 || cmd.mul2) prod_r <= prod_nxt;
    neg_r      <= neg_nxt;
    aerr_r     <= aerr_nxt;
    base_r     <= base_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> rtl/wall_follow_turn_controller_core.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake                Contents
// in_      slave      in_tvalid / in_tready    one control tick: three ranges and yaw rate
// out_     master     out_tvalid / out_tready  wheel speeds, mode, heading target
// cfg_     slave      cfg_valid / cfg_ready    register index and write data
//
// The result word turns valid at the commit edge, after gyro or base-speed product,
// heading integration and gain product; commit waits while the output register is
// full. in_tready rises at that same edge, so no new tick is taken before the last
// one commits, as the single shared multiplier is used twice. cfg_ready is always high.
// Reset (rst_n low, synchronous) loads the register defaults and the turn state.
// A stalled result waits in the output register while the next tick runs up to its
// commit step and holds there until the word drains, so no word is lost or doubled.
module wall_follow_turn_controller_core
  import wftc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // [11:0] left_distance, [23:12] front_distance, [35:24] right_distance,
  // [51:36] yaw_rate, [55:52] zero
  input  logic [55:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] left wheel speed, [31:16] right wheel speed, [33:32] mode,
  // [49:34] heading_target, [55:50] zero
  output logic [55:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  wftc_cmd_t    cmd;
  wftc_status_t status;

  // registers accept a write in any cycle
  assign cfg_ready = 1'b1;

  wftc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  wftc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> verif/tb_wall_follow_turn_controller_core.sv
`timescale 1ns / 1ps
module tb_wall_follow_turn_controller_core;
  import wftc_pkg::*;

  localparam int     CLK_HIGH_NS   = 6;
  localparam int     CLK_LOW_NS    = 6;
  localparam int     IDLE_LIMIT    = 2000;  // cycles with no word moving anywhere
  localparam int     HOLD_CYCLES   = 80;    // long receiver hold-off
  localparam int     SETTLE_CYCLES = 12;    // settle time before the summary
  localparam int     PLAN_ROWS     = 24;
  localparam int     PHASE_COUNT   = 10;
  localparam int     PHASE_TICKS   = 183;
  localparam int     TOP_PHASE     = 2;     // every register at its top value
  localparam int     BOTTOM_PHASE  = 5;     // every register at zero
  localparam int     HOLD_PHASE    = 3;
  localparam int     PAUSE_PHASE   = 4;
  localparam int     REPORT_CAP    = 40;
  // Angle units per unit of yaw rate in one tick, scaled by 2^24
  localparam longint GYRO_SCALE    = 683565;
  localparam longint GYRO_SPAN     = 64 * GYRO_SCALE;

  typedef struct packed {
    logic [11:0] left;
    logic [11:0] front;
    logic [11:0] right;
    logic [15:0] yaw;
  } tick_t;

  typedef struct packed {
    logic [15:0] left_wheel;
    logic [15:0] right_wheel;
    logic [1:0]  mode;
    logic [15:0] target;
  } wheel_cmd_t;

  typedef struct packed {
    tick_t      tick;
    logic       aim;    // replace the yaw by one that lands on the target
    logic       typed;  // expectation written out by hand below
    wheel_cmd_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [55:0] in_tdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_SPEED_LIMIT;
  logic [15:0] cfg_data = '0;

  // Controller settings as the block should hold them
  logic [14:0] lim_speed       = 15'd2145;
  logic [15:0] turn_gain       = 16'd314;
  logic [15:0] follow_gain     = 16'd4915;
  logic [11:0] follow_setpoint = 12'd112;
  logic [11:0] open_level      = 12'd240;
  logic [11:0] stop_level      = 12'd64;
  logic [14:0] align_tol       = 15'd104;
  logic [7:0]  coast_limit     = 8'd13;

  // Turn state as the block should hold it
  logic        seed_pending = 1'b1;
  logic [1:0]  ctl_mode     = MODE_CURVE;
  logic [1:0]  resume_mode  = MODE_CURVE;
  logic [15:0] target_ang   = 16'd0;
  logic [15:0] heading_ang  = 16'd0;
  logic [7:0]  coast_ticks  = 8'd255;

  wheel_cmd_t  pending_cmds[$];
  plan_row_t   plan [PLAN_ROWS];
  logic [15:0] phase_regs [8];

  int fail_count    = 0;
  int ticks_sent    = 0;
  int words_checked = 0;
  int turns_done    = 0;
  int new_dirs      = 0;
  int reg_writes    = 0;
  int idle_cycles   = 0;
  int burst_left    = 0;
  bit sender_bursty = 1'b1;

  // Receiver side: hold-off request from the stimulus, pattern state of its own
  bit         hold_request = 1'b0;
  int         hold_left    = 0;
  int         style_left   = 0;
  int         ready_style  = 0;
  logic [7:0] ready_ring   = 8'b0001_0011;

  always begin
    clk = 1'b1;
    #CLK_HIGH_NS;
    clk = 1'b0;
    #CLK_LOW_NS;
  end

  wall_follow_turn_controller_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Controller prediction
  // ---------------------------------------------------------------------------

  function automatic longint half_up_div256(input longint v);
    if (v < 0) return -((-v + 128) >>> 8);
    return (v + 128) >>> 8;
  endfunction

  function automatic longint bound_speed(input longint v);
    longint m;
    m = longint'(lim_speed);
    if (v > m) return m;
    if (v < -m) return -m;
    return v;
  endfunction

  // First side at or above the level wins: left, then front, then right, else back
  function automatic logic [15:0] open_side(input logic [11:0] l, input logic [11:0] f,
                                            input logic [11:0] r, input logic [11:0] lvl);
    if (l >= lvl) return ANGLE_LEFT;
    if (f >= lvl) return ANGLE_FRONT;
    if (r >= lvl) return ANGLE_RIGHT;
    return ANGLE_BACK;
  endfunction

  task automatic advance_controller(input tick_t t, output wheel_cmd_t w);
    longint      ls;
    longint      rs;
    longint      mag;
    longint      step;
    longint      base;
    longint      corr;
    logic [15:0] du;
    logic [15:0] dir;
    logic [15:0] diff;
    int          yaw_v;
    int          err;
    int          aerr;
    yaw_v = int'($signed(t.yaw));
    ls = 0;
    rs = 0;
    // The very first tick seeds the target from the seed threshold test, then wall-follows
    if (seed_pending) begin
      seed_pending = 1'b0;
      ctl_mode = MODE_WALL;
      target_ang = target_ang + open_side(t.left, t.front, t.right, SEED_THRESHOLD);
    end
    case (ctl_mode)
      MODE_COAST: begin
        if (coast_ticks > coast_limit) ctl_mode = resume_mode;
        rs = (t.front <= stop_level) ? 64'sd0 : longint'(lim_speed);
        ls = rs;
      end
      MODE_CURVE: begin
        mag = (yaw_v < 0) ? -longint'(yaw_v) : longint'(yaw_v);
        step = (mag * GYRO_SPAN + 64'sd8388608) >>> 24;
        du = step[15:0];
        heading_ang = (yaw_v < 0) ? heading_ang - du : heading_ang + du;
        diff = target_ang - heading_ang;
        err = int'($signed(diff));
        rs = half_up_div256(longint'(turn_gain) * longint'(err));
        ls = -rs;
        aerr = (err < 0) ? -err : err;
        // Speeds of the aligning tick still go out; angles restart from zero
        if (aerr < int'(align_tol)) begin
          ctl_mode = MODE_COAST;
          resume_mode = MODE_WALL;
          coast_ticks = 8'd0;
          heading_ang = 16'd0;
          target_ang = 16'd0;
          turns_done++;
        end
      end
      default: begin
        base = (longint'(lim_speed) * 4 + 2) / 5;
        corr = half_up_div256(longint'(follow_gain) *
                              (longint'(t.left) - longint'(follow_setpoint)));
        dir = open_side(t.left, t.front, t.right, open_level);
        rs = base + corr;
        ls = base - corr;
        if (dir != target_ang) begin
          coast_ticks = 8'd0;
          ctl_mode = MODE_COAST;
          target_ang = dir;
          resume_mode = MODE_CURVE;
          rs = base;
          ls = base;
          new_dirs++;
        end
      end
    endcase
    ls = bound_speed(ls);
    rs = bound_speed(rs);
    if (coast_ticks != 8'd255) coast_ticks++;
    w.left_wheel = ls[15:0];
    w.right_wheel = rs[15:0];
    w.mode = ctl_mode;
    w.target = target_ang;
  endtask

  task automatic store_setting(input logic [2:0] idx, input logic [15:0] data);
    case (idx)
      REG_SPEED_LIMIT:   lim_speed = data[14:0];
      REG_CURVE_GAIN:    turn_gain = data;
      REG_WALL_GAIN:     follow_gain = data;
      REG_WALL_SETPOINT: follow_setpoint = data[11:0];
      REG_OPEN_THRESH:   open_level = data[11:0];
      REG_STOP_DIST:     stop_level = data[11:0];
      REG_ALIGNED_TOL:   align_tol = data[14:0];
      REG_RUN_TICKS:     coast_limit = data[7:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Yaw that carries the heading onto the target in one tick, plus some jitter
  function automatic logic [15:0] aim_yaw(input int jitter);
    logic [15:0] diff;
    longint      err;
    longint      y;
    diff = target_ang - heading_ang;
    err = longint'($signed(diff));
    y = (err * 64'sd16777216) / GYRO_SPAN + jitter;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return y[15:0];
  endfunction

  function automatic logic [11:0] near_level(input int v);
    int x;
    x = v + int'($urandom_range(0, 4)) - 2;
    if (x < 0) x = 0;
    if (x > 4095) x = 4095;
    return x[11:0];
  endfunction

  function automatic logic [11:0] under_level(input logic [11:0] lvl);
    if (lvl == 12'd0) return 12'd0;
    return 12'($urandom_range(0, int'(lvl) - 1));
  endfunction

  function automatic logic [11:0] any_range();
    case ($urandom_range(0, 7))
      0:       return 12'd0;
      1:       return 12'd4095;
      2:       return near_level(int'(open_level));
      3:       return near_level(int'(stop_level));
      default: return 12'($urandom);
    endcase
  endfunction

  // Left reading that keeps the side closed, mostly hugging the setpoint
  function automatic logic [11:0] hug_left();
    logic [11:0] l;
    if (follow_setpoint < open_level && $urandom_range(0, 1) == 1) begin
      l = near_level(int'(follow_setpoint) + int'($urandom_range(0, 60)) - 30);
      if (l >= open_level) l = open_level - 12'd1;
      return l;
    end
    return under_level(open_level);
  endfunction

  // Mostly well-formed ticks for the mode the controller is in, the rest noise
  function automatic tick_t next_tick();
    tick_t t;
    int    pick;
    t.left = any_range();
    t.front = any_range();
    t.right = any_range();
    t.yaw = 16'($urandom);
    pick = $urandom_range(0, 9);
    case (ctl_mode)
      MODE_CURVE: begin
        if (pick < 7) t.yaw = aim_yaw(int'($urandom_range(0, 6)) - 3);
        else if (pick == 7) t.yaw = 16'(int'($urandom_range(0, 400)) - 200);
      end
      MODE_WALL: begin
        // Hold the current direction so the wall-follow law gets exercised
        if (pick < 7) begin
          case (target_ang)
            ANGLE_LEFT: t.left = 12'($urandom_range(int'(open_level), 4095));
            ANGLE_FRONT: begin
              t.left = hug_left();
              t.front = 12'($urandom_range(int'(open_level), 4095));
            end
            ANGLE_RIGHT: begin
              t.left = hug_left();
              t.front = under_level(open_level);
              t.right = 12'($urandom_range(int'(open_level), 4095));
            end
            default: begin
              t.left = hug_left();
              t.front = under_level(open_level);
              t.right = under_level(open_level);
            end
          endcase
        end
      end
      default: begin
        if (pick < 3) t.front = near_level(int'(stop_level));
      end
    endcase
    return t;
  endfunction

  function automatic logic [15:0] with_junk(input int unsigned v, input int w);
    logic [31:0] j;
    j = $urandom;
    return 16'(v | (j << w));
  endfunction

  function automatic plan_row_t step_row(input int l, input int f, input int r,
                                         input int yaw, input logic aim);
    plan_row_t p;
    p = '0;
    p.tick.left = l[11:0];
    p.tick.front = f[11:0];
    p.tick.right = r[11:0];
    p.tick.yaw = yaw[15:0];
    p.aim = aim;
    return p;
  endfunction

  function automatic plan_row_t typed_row(input plan_row_t p, input int ls, input int rs,
                                          input logic [1:0] mode, input logic [15:0] tgt);
    p.typed = 1'b1;
    p.want.left_wheel = ls[15:0];
    p.want.right_wheel = rs[15:0];
    p.want.mode = mode;
    p.want.target = tgt;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Offer one tick word at the falling edge and hold it until taken
  task automatic send_tick(input tick_t t, input logic typed, input wheel_cmd_t typed_want);
    wheel_cmd_t w;
    @(negedge clk);
    in_tdata <= {4'b0000, t.yaw, t.right, t.front, t.left};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    advance_controller(t, w);
    pending_cmds.push_back(typed ? typed_want : w);
    ticks_sent++;
  endtask

  // Bursts of random length, random gaps between them
  task automatic pace_sender();
    int gap;
    if (!sender_bursty) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap = $urandom_range(1, 20);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (gap - 1) @(negedge clk);
    burst_left = $urandom_range(0, 30);
  endtask

  // Stop offering and wait for every expected word to come back
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    store_setting(idx, data);
    reg_writes++;
  endtask

  // Pick a setting for the phase and write all eight registers; junk rides above
  // the width of each register narrower than 16 bits so the masking gets tested too
  task automatic retune_controller(input int phase);
    if (phase == TOP_PHASE) begin
      foreach (phase_regs[i]) phase_regs[i] = 16'hFFFF;
    end else if (phase == BOTTOM_PHASE) begin
      foreach (phase_regs[i]) phase_regs[i] = 16'h0000;
    end else begin
      phase_regs[REG_SPEED_LIMIT] = with_junk(($urandom_range(0, 3) == 0) ?
          $urandom_range(1, 32767) : $urandom_range(800, 6000), 15);
      phase_regs[REG_CURVE_GAIN] = ($urandom_range(0, 4) == 0) ?
          16'($urandom) : 16'($urandom_range(50, 1500));
      phase_regs[REG_WALL_GAIN] = ($urandom_range(0, 4) == 0) ?
          16'($urandom) : 16'($urandom_range(500, 12000));
      phase_regs[REG_WALL_SETPOINT] = with_junk($urandom_range(40, 600), 12);
      phase_regs[REG_OPEN_THRESH] = with_junk(($urandom_range(0, 5) == 0) ?
          $urandom_range(0, 4095) : $urandom_range(120, 900), 12);
      phase_regs[REG_STOP_DIST] = with_junk($urandom_range(0, 500), 12);
      phase_regs[REG_ALIGNED_TOL] = with_junk(($urandom_range(0, 5) == 0) ?
          $urandom_range(0, 32767) : $urandom_range(40, 3000), 15);
      phase_regs[REG_RUN_TICKS] = with_junk(($urandom_range(0, 7) == 0) ?
          254 : $urandom_range(0, 20), 8);
    end
    write_reg(REG_SPEED_LIMIT,   phase_regs[REG_SPEED_LIMIT]);
    write_reg(REG_CURVE_GAIN,    phase_regs[REG_CURVE_GAIN]);
    write_reg(REG_WALL_GAIN,     phase_regs[REG_WALL_GAIN]);
    write_reg(REG_WALL_SETPOINT, phase_regs[REG_WALL_SETPOINT]);
    write_reg(REG_OPEN_THRESH,   phase_regs[REG_OPEN_THRESH]);
    write_reg(REG_STOP_DIST,     phase_regs[REG_STOP_DIST]);
    write_reg(REG_ALIGNED_TOL,   phase_regs[REG_ALIGNED_TOL]);
    write_reg(REG_RUN_TICKS,     phase_regs[REG_RUN_TICKS]);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (fail_count < REPORT_CAP)
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  task automatic compare_field(input string what, input longint got, input longint want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Take each result word at the rising edge and hold it against the oldest expectation
  always @(posedge clk) begin
    wheel_cmd_t got;
    wheel_cmd_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.left_wheel = out_tdata[15:0];
      got.right_wheel = out_tdata[31:16];
      got.mode = out_tdata[33:32];
      got.target = out_tdata[49:34];
      if (pending_cmds.size() == 0) begin
        report_mismatch("word with no tick waiting, left speed",
                        longint'($signed(got.left_wheel)), 64'sd0);
      end else begin
        want = pending_cmds.pop_front();
        compare_field("left speed", longint'($signed(got.left_wheel)),
                      longint'($signed(want.left_wheel)));
        compare_field("right speed", longint'($signed(got.right_wheel)),
                      longint'($signed(want.right_wheel)));
        compare_field("mode", longint'(got.mode), longint'(want.mode));
        compare_field("heading target", longint'($signed(got.target)),
                      longint'($signed(want.target)));
        words_checked++;
      end
    end
  end

  // Receiver: a long hold-off on request, otherwise a stall style that changes now
  // and then (always ready, coin toss, a rotating ring, mostly ready)
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        style_left = $urandom_range(20, 120);
        ready_style = $urandom_range(0, 3);
      end
      style_left--;
      case (ready_style)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: begin
          out_tready <= ready_ring[0];
          ready_ring = {ready_ring[0], ready_ring[7:1]};
        end
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Watchdog: end the run if no word moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending_cmds.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    tick_t t;

    // Directed walk: seed with nothing open (target straight back), then through
    // a new direction, coast with the front at the stop distance, a curve with
    // the gyro extremes, alignment, and the right and back turns. Error of
    // exactly pi is hit on the tick before the last.
    plan[0]  = typed_row(step_row(0, 0, 0, 0, 1'b0), 2145, -434, MODE_WALL, ANGLE_BACK);
    plan[1]  = typed_row(step_row(4095, 4095, 4095, 32767, 1'b0), 1716, 1716,
                         MODE_COAST, ANGLE_LEFT);
    plan[2]  = typed_row(step_row(100, 64, 100, 0, 1'b0), 0, 0, MODE_COAST, ANGLE_LEFT);
    plan[3]  = typed_row(step_row(100, 65, 100, -32768, 1'b0), 2145, 2145,
                         MODE_CURVE, ANGLE_LEFT);
    plan[4]  = step_row(0, 0, 0, 32767, 1'b0);
    plan[5]  = step_row(0, 0, 0, -32768, 1'b0);
    plan[6]  = step_row(4095, 0, 4095, 0, 1'b0);
    plan[7]  = step_row(0, 0, 0, 0, 1'b1);
    plan[8]  = step_row(0, 4095, 0, 0, 1'b0);
    plan[9]  = step_row(0, 4095, 0, 0, 1'b0);
    plan[10] = step_row(112, 4095, 0, 0, 1'b0);
    plan[11] = step_row(0, 4095, 0, 0, 1'b0);
    plan[12] = step_row(239, 4095, 0, 0, 1'b0);
    plan[13] = step_row(0, 239, 4095, -1, 1'b0);
    plan[14] = step_row(0, 0, 4095, 0, 1'b0);
    plan[15] = step_row(0, 0, 4095, 0, 1'b0);
    plan[16] = step_row(0, 0, 4095, 0, 1'b1);
    plan[17] = step_row(0, 4095, 0, 0, 1'b0);
    plan[18] = step_row(0, 4095, 0, 0, 1'b0);
    plan[19] = step_row(0, 0, 0, 0, 1'b0);
    plan[20] = step_row(0, 0, 0, 0, 1'b0);
    plan[21] = step_row(0, 0, 0, 0, 1'b0);
    plan[22] = step_row(0, 0, 0, 0, 1'b0);
    plan[23] = step_row(0, 0, 0, 0, 1'b1);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Shorten coasting so the directed walk reaches every mode quickly
    write_reg(REG_RUN_TICKS, 16'd1);
    @(negedge clk);
    cfg_valid <= 1'b0;

    foreach (plan[i]) begin
      t = plan[i].tick;
      if (plan[i].aim) t.yaw = aim_yaw(0);
      send_tick(t, plan[i].typed, plan[i].want);
      pace_sender();
    end
    drain_results();

    // Random phases, each under its own register setting
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      retune_controller(phase);
      sender_bursty = (phase % 3 != 1) && (phase != HOLD_PHASE);
      for (int n = 0; n < PHASE_TICKS; n++) begin
        // Block the receiver while ticks keep coming, so the input backs up
        if (phase == HOLD_PHASE && n == 40) hold_request = 1'b1;
        // Let everything drain in the middle of a phase once
        if (phase == PAUSE_PHASE && n == 90) drain_results();
        send_tick(next_tick(), 1'b0, '0);
        pace_sender();
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d ticks under %0d settings and %0d register writes",
             ticks_sent, PHASE_COUNT + 1, reg_writes);
    $display("checked %0d result words, %0d turns finished, %0d new directions taken",
             words_checked, turns_done, new_dirs);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
